// ===== rtl/hkt_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hkt_pkg: shared types and constants of the hashed key table
// Field widths, table geometry, bucket row layout, opcodes and FSM states.
// ---------------------------------------------------------------------------
package hkt_pkg;

    // table geometry
    localparam int BUCKETS = 128;
    localparam int WAYS    = 8;
    localparam int SLOTS   = BUCKETS * WAYS;

    // field widths
    localparam int KIND_W = 2;
    localparam int KEY_W  = 20;
    localparam int PAY_W  = 16;
    localparam int CNT_W  = 11;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // derived index widths
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    // bucket selection: a plain mask for a power-of-two bucket count,
    // otherwise a reciprocal multiply with one correction step
    localparam bit BKT_POW2 = ((1 << BKT_W) == BUCKETS);
    localparam int RCP_SH   = KEY_W;
    localparam int PROD_W   = 2 * KEY_W;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((1 << RCP_SH) / BUCKETS);

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_kind_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_UPDATE
    } state_t;

    // one bucket: all ways side by side in one memory word
    typedef struct packed {
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][KEY_W-1:0] key;
        logic [WAYS-1:0][PAY_W-1:0] payload;
    } row_t;

endpackage
`default_nettype wire

// ===== rtl/hashed_key_table.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hashed_key_table: keyed record table with fixed-way buckets
// Insert, remove and lookup of records by key; each bucket is one wide
// memory word that is read, compared across all ways and, when an insert or remove changes it, written back.
// ---------------------------------------------------------------------------
//
//  channel | direction | signals                                 | meaning
//  --------+-----------+-----------------------------------------+-----------------
//  req     | in        | req_valid req_ready kind key payload    | one operation
//  rsp     | out       | rsp_valid rsp_ready success bucket_full | one result per
//          |           | found_payload record_count              | request
//
//  Steps: for a power-of-two bucket count a transaction is one bucket read at accept
//  and one compare and write back; any other count first runs S_HASH and S_FOLD for
//  the reciprocal multiply that forms key modulo the bucket count, then reads the bucket.
//  Reset: a clearing pass frees every bucket (BUCKETS, 128 here), one per cycle;
//  req_ready stays low until it ends.
//  Stalls: a request is taken while a result waits; the update step holds until it is taken.
//
module hashed_key_table
(
    input  wire                       clk,
    input  wire                       rst_n,

    input  wire                       req_valid,
    output logic                      req_ready,
    input  wire [hkt_pkg::KIND_W-1:0] kind,
    input  wire [hkt_pkg::KEY_W-1:0]  key,
    input  wire [hkt_pkg::PAY_W-1:0]  payload,

    output logic                      rsp_valid,
    input  wire                       rsp_ready,
    output logic                      success,
    output logic                      bucket_full,
    output logic [hkt_pkg::PAY_W-1:0] found_payload,
    output logic [hkt_pkg::CNT_W-1:0] record_count
);
    import hkt_pkg::*;

    // -----------------------------------------------------------------------
    // control state
    // -----------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [BKT_W-1:0]   clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg;

    // request held for the duration of the transaction
    logic [KIND_W-1:0]  kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PAY_W-1:0]   pay_reg;
    logic [BKT_W-1:0]   bkt_reg, bkt_next;
    logic               bkt_load;
    logic [KEY_W-1:0]   quo_reg;

    // response register
    logic               success_reg;
    logic               full_reg;
    logic [PAY_W-1:0]   fpay_reg;
    logic [CNT_W-1:0]   rcount_reg;
    logic               rsp_load;

    // bucket memory ports
    row_t               mem [BUCKETS];
    row_t               rd_row_reg;
    logic               rd_en;
    logic [BKT_W-1:0]   rd_addr;
    logic               mem_we;
    logic [BKT_W-1:0]   wr_addr;
    row_t               wr_row;

    logic               req_acc;

    // bucket arithmetic for the non-power-of-two case
    logic [PROD_W-1:0]  prod;
    logic [KEY_W-1:0]   quo_b;
    logic [KEY_W-1:0]   rem_raw;
    logic [KEY_W-1:0]   rem;

    // compare and modify results
    logic [WAYS-1:0]    hit_vec;
    logic [WAYS-1:0]    free_vec;
    logic               hit_any;
    logic               free_any;
    logic [WAY_W-1:0]   hit_idx;
    logic [WAY_W-1:0]   free_idx;
    row_t               upd_row;
    logic               upd_we;
    logic [CNT_W-1:0]   upd_count;
    logic               upd_ok;
    logic               upd_full;
    logic [PAY_W-1:0]   upd_fpay;

    assign req_ready = (state_reg == S_IDLE);
    assign req_acc   = req_valid && req_ready;

    assign rsp_valid     = rsp_valid_reg;
    assign success       = success_reg;
    assign bucket_full   = full_reg;
    assign found_payload = fpay_reg;
    assign record_count  = rcount_reg;

    // -----------------------------------------------------------------------
    // bucket index: quotient estimate is low by at most one, so the
    // remainder stays below twice the bucket count
    // -----------------------------------------------------------------------
    always_comb
    begin
        prod    = PROD_W'(key_reg) * PROD_W'(RECIP);
        quo_b   = quo_reg * KEY_W'(BUCKETS);
        rem_raw = key_reg - quo_b;
        if (rem_raw >= KEY_W'(BUCKETS))
        begin
            rem = rem_raw - KEY_W'(BUCKETS);
        end
        else
        begin
            rem = rem_raw;
        end
    end

    // -----------------------------------------------------------------------
    // compare all ways of the bucket in parallel; lowest way wins
    // -----------------------------------------------------------------------
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = rd_row_reg.valid[w] && (rd_row_reg.key[w] == key_reg);
            free_vec[w] = !rd_row_reg.valid[w];
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                free_idx = WAY_W'(w);
            end
        end
        hit_any  = |hit_vec;
        free_any = |free_vec;
    end

    // -----------------------------------------------------------------------
    // modify the bucket according to the operation
    // -----------------------------------------------------------------------
    always_comb
    begin
        upd_row   = rd_row_reg;
        upd_we    = 1'b0;
        upd_count = count_reg;
        upd_ok    = 1'b0;
        upd_full  = 1'b0;
        upd_fpay  = '0;
        case (kind_reg)
            OP_INSERT:
            begin
                if (!hit_any)
                begin
                    if (free_any)
                    begin
                        upd_row.valid[free_idx]   = 1'b1;
                        upd_row.key[free_idx]     = key_reg;
                        upd_row.payload[free_idx] = pay_reg;
                        upd_we    = 1'b1;
                        upd_count = count_reg + CNT_W'(1);
                        upd_ok    = 1'b1;
                    end
                    else
                    begin
                        upd_full = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit_any)
                begin
                    upd_row.valid[hit_idx] = 1'b0;
                    upd_we    = 1'b1;
                    upd_count = count_reg - CNT_W'(1);
                    upd_ok    = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_any)
                begin
                    upd_ok   = 1'b1;
                    upd_fpay = rd_row_reg.payload[hit_idx];
                end
            end
            default:
            begin
                // unused opcode: report the current count, change nothing
                upd_ok = 1'b0;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // sequencer: next state, memory port control, response load
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        rd_en        = 1'b0;
        rd_addr      = key[BKT_W-1:0];
        mem_we       = 1'b0;
        wr_addr      = bkt_reg;
        wr_row       = upd_row;
        bkt_load     = 1'b0;
        bkt_next     = key[BKT_W-1:0];
        rsp_load     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // sweep the memory, freeing every way of each bucket
                mem_we       = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_row       = '0;
                clr_idx_next = clr_idx_reg + BKT_W'(1);
                if (clr_idx_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (BKT_POW2)
                    begin
                        // issue the bucket read straight from the request
                        rd_en      = 1'b1;
                        bkt_load   = 1'b1;
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                rd_en      = 1'b1;
                rd_addr    = rem[BKT_W-1:0];
                bkt_load   = 1'b1;
                bkt_next   = rem[BKT_W-1:0];
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold while the previous result has not been taken
                if (!rsp_valid_reg || rsp_ready)
                begin
                    mem_we     = upd_we;
                    count_next = upd_count;
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // payload registers: request, bucket index, quotient, response
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            pay_reg  <= payload;
        end
        if (bkt_load)
        begin
            bkt_reg <= bkt_next;
        end
        if (state_reg == S_HASH)
        begin
            quo_reg <= prod[RCP_SH +: KEY_W];
        end
        if (rsp_load)
        begin
            success_reg <= upd_ok;
            full_reg    <= upd_full;
            fpay_reg    <= upd_fpay;
            rcount_reg  <= upd_count;
        end
    end

    // -----------------------------------------------------------------------
    // bucket memory: one write port, one registered read port
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && rd_en))
        else $error("bucket read and write in the same cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (SLOTS > CNT_MAX) || (count_reg <= CNT_W'(SLOTS)))
        else $error("record count above table capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) ||
        (count_reg == $past(count_reg) + CNT_W'(1)) ||
        (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("record count moved by more than one");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(success_reg && full_reg))
        else $error("success and bucket_full both set");

    a_payload_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (fpay_reg != '0)) |-> success_reg)
        else $error("payload returned without a hit");

endmodule
`default_nettype wire
